// ===== rtl/core/mipd_pkg.sv =====
// Shared types, constants and channel arithmetic for the mip chain downsampler.
`timescale 1ns / 1ps
`default_nettype none
package mipd_pkg;

	localparam int MAXL  = 10;            // log2 of the largest level-0 width
	localparam int NLVL  = MAXL + 1;      // levels including level 0
	localparam int NGEN  = MAXL;          // levels that can be generated
	localparam int CH    = 4;             // channels per pixel
	localparam int PSW   = 9 * CH;        // pair sum word
	localparam int FDEPTH = 4;            // result queue entries

	localparam logic [1:0] REG_WIDTH_LOG2  = 2'd0;
	localparam logic [1:0] REG_HEIGHT_LOG2 = 2'd1;
	localparam logic [1:0] REG_MIP_LEVELS  = 2'd2;

	typedef struct packed {
		logic [8:0]  x;
		logic [8:0]  y;
		logic [31:0] pix;
	} res_t;

	typedef struct packed {
		logic             vld;
		logic             alive;
		logic [31:0]      pix;
		logic [3:0]       nres;
		res_t [NGEN-1:0]  res;
	} item_t;

	typedef struct packed {
		logic [3:0]      nres;
		res_t [NGEN-1:0] res;
	} fifo_ent_t;

	typedef struct packed {
		logic       gen;
		logic [3:0] wsh;
		logic [3:0] hsh;
	} lvl_cfg_t;

	typedef struct packed {
		logic             re;
		logic [8:0]       raddr;
		logic             we;
		logic [8:0]       waddr;
		logic [PSW-1:0]   wdata;
	} ram_req_t;

	function automatic logic [PSW-1:0] pair_sum(input logic [31:0] a, input logic [31:0] b);
		logic [PSW-1:0] r;
		r = '0;
		for (int c = 0; c < CH; c++) begin
			r[9*c +: 9] = 9'(a[8*c +: 8]) + 9'(b[8*c +: 8]);
		end
		return r;
	endfunction

	function automatic logic [31:0] average(input logic [PSW-1:0] t, input logic [PSW-1:0] b);
		logic [31:0] r;
		logic [9:0]  s;
		r = '0;
		for (int c = 0; c < CH; c++) begin
			s = 10'(t[9*c +: 9]) + 10'(b[9*c +: 9]);
			r[8*c +: 8] = s[9:2];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mipd_ram.sv =====
// Simple dual-port line store with registered read.
`timescale 1ns / 1ps
`default_nettype none
module mipd_ram #(
	parameter int AW = 1
) (
	input  wire logic                      clk,
	input  wire logic                      re,
	input  wire logic [AW-1:0]             raddr,
	output logic [mipd_pkg::PSW-1:0]       rdata,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [mipd_pkg::PSW-1:0]  wdata
);

	logic [mipd_pkg::PSW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/mipd_cell.sv =====
// One mip level: position counters, left pixel, pair sum and 2x2 average.
`timescale 1ns / 1ps
`default_nettype none
module mipd_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      clr,
	input  wire logic [3:0]                lvl,
	input  wire mipd_pkg::lvl_cfg_t        cfg,
	input  wire mipd_pkg::item_t           din,
	output mipd_pkg::item_t                dout,
	output mipd_pkg::ram_req_t             ram,
	input  wire logic [mipd_pkg::PSW-1:0]  ram_rdata
);

	logic [mipd_pkg::MAXL-1:0] col_q, row_q;
	logic [31:0]               held_q;
	logic [mipd_pkg::MAXL:0]   col_lim, row_lim;
	logic                      col_last, row_last, step, act;

	mipd_pkg::item_t           item_s1, nxt, dout_q;
	logic                      emit_s1, wr_s1;
	logic [mipd_pkg::PSW-1:0]  ps_s1;
	logic [8:0]                x_s1, y_s1;
	logic [31:0]               avg;

	assign col_lim  = ((mipd_pkg::MAXL+1)'(1) << cfg.wsh) - (mipd_pkg::MAXL+1)'(1);
	assign row_lim  = ((mipd_pkg::MAXL+1)'(1) << cfg.hsh) - (mipd_pkg::MAXL+1)'(1);
	assign col_last = {1'b0, col_q} == col_lim;
	assign row_last = {1'b0, row_q} == row_lim;
	assign step     = en & din.vld & din.alive;
	assign act      = din.vld & din.alive & cfg.gen & col_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (clr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// left pixel of the pair
	always_ff @(posedge clk) begin
		if (step && cfg.gen && !col_q[0]) begin
			held_q <= din.pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
			emit_s1 <= 1'b0;
			wr_s1   <= 1'b0;
		end else if (en) begin
			item_s1 <= din;
			emit_s1 <= act & row_q[0];
			wr_s1   <= act & ~row_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ps_s1 <= mipd_pkg::pair_sum(held_q, din.pix);
			x_s1  <= col_q[mipd_pkg::MAXL-1 -: 9];
			y_s1  <= row_q[mipd_pkg::MAXL-1 -: 9];
		end
	end

	// even rows park the pair sum, odd rows fetch it
	assign ram.re    = en & act & row_q[0];
	assign ram.raddr = col_q[mipd_pkg::MAXL-1 -: 9];
	assign ram.we    = en & wr_s1;
	assign ram.waddr = x_s1;
	assign ram.wdata = ps_s1;

	assign avg = mipd_pkg::average(ram_rdata, ps_s1);

	always_comb begin
		nxt       = item_s1;
		nxt.alive = item_s1.vld & emit_s1;
		if (emit_s1) begin
			nxt.pix            = avg;
			nxt.nres           = lvl + 4'd1;
			nxt.res[lvl].x     = x_s1;
			nxt.res[lvl].y     = y_s1;
			nxt.res[lvl].pix   = avg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_q <= '0;
		end else if (en) begin
			dout_q <= nxt;
		end
	end

	assign dout = dout_q;

endmodule
`default_nettype wire

// ===== rtl/core/mip_chain_box_downsampler.sv =====
// Top level: level cells in a chain, per-level line stores and the result queue.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+---------------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready| tdata: src_pixel
//  m_axis  | out | m_axis_tvalid/m_axis_tready| tdata: level,out_x,out_y,out_pixel; tlast
//  cfg     | in  | cfg_we (no wait)           | cfg_idx, cfg_wdata
//
// One source pixel per cycle. Each level cell registers an item in item_s1 and
// then in dout_q; an item crosses the ten cells and all its results leave together.
// Results drain one per cycle from a 4-entry queue while m_axis_tready is high;
// input stalls only when that queue is full, and the whole chain holds while it does.
// Reset (and any valid config write) restarts the frame counters; the line
// stores are not cleared, every entry is written before it is read.
`timescale 1ns / 1ps
`default_nettype none
module mip_chain_box_downsampler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] src_pixel
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,   // [3:0] level, [12:4] out_x, [21:13] out_y,
	                                         // [53:22] out_pixel, [55:54] zero
	output logic             m_axis_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [3:0]  cfg_wdata
);

	localparam int NG = mipd_pkg::NGEN;

	logic [3:0] wl_q, hl_q, ml_q;
	logic       clr, en;

	mipd_pkg::item_t    chain [NG+1];
	mipd_pkg::lvl_cfg_t lcfg  [NG];
	mipd_pkg::ram_req_t rreq  [NG];
	logic [mipd_pkg::PSW-1:0] rdata [NG];

	// config: sizes saturate on write, a valid write restarts the frame
	assign clr = cfg_we & (cfg_idx == mipd_pkg::REG_WIDTH_LOG2 ||
	                       cfg_idx == mipd_pkg::REG_HEIGHT_LOG2 ||
	                       cfg_idx == mipd_pkg::REG_MIP_LEVELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= 4'(mipd_pkg::MAXL);
			hl_q <= 4'(mipd_pkg::MAXL);
			ml_q <= 4'(mipd_pkg::NLVL);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				mipd_pkg::REG_WIDTH_LOG2:
					wl_q <= (cfg_wdata > 4'(mipd_pkg::MAXL)) ? 4'(mipd_pkg::MAXL) : cfg_wdata;
				mipd_pkg::REG_HEIGHT_LOG2:
					hl_q <= (cfg_wdata > 4'(mipd_pkg::MAXL)) ? 4'(mipd_pkg::MAXL) : cfg_wdata;
				mipd_pkg::REG_MIP_LEVELS: begin
					if (cfg_wdata == 4'd0) ml_q <= 4'd1;
					else if (cfg_wdata > 4'(mipd_pkg::NLVL)) ml_q <= 4'(mipd_pkg::NLVL);
					else ml_q <= cfg_wdata;
				end
				default: ;
			endcase
		end
	end

	// result queue: one entry per source pixel that made results
	mipd_pkg::fifo_ent_t fifo_q [mipd_pkg::FDEPTH];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic [3:0] slot_q;
	logic       push, pop, last;
	mipd_pkg::fifo_ent_t head;
	mipd_pkg::res_t      r;

	assign en            = cnt_q != 3'(mipd_pkg::FDEPTH);
	assign s_axis_tready = en;

	always_comb begin
		chain[0]       = '0;
		chain[0].vld   = s_axis_tvalid & en;
		chain[0].alive = 1'b1;
		chain[0].pix   = s_axis_tdata;
	end

	for (genvar k = 0; k < NG; k++) begin : g_lvl
		localparam logic [3:0] K  = 4'(k);
		localparam int         AW = (mipd_pkg::MAXL - 1 - k > 0) ? mipd_pkg::MAXL - 1 - k : 1;

		assign lcfg[k].gen = (K + 4'd1 < ml_q) && (wl_q >= K + 4'd1) && (hl_q >= K + 4'd1);
		assign lcfg[k].wsh = (wl_q >= K) ? wl_q - K : 4'd0;
		assign lcfg[k].hsh = (hl_q >= K) ? hl_q - K : 4'd0;

		mipd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.clr       (clr),
			.lvl       (K),
			.cfg       (lcfg[k]),
			.din       (chain[k]),
			.dout      (chain[k+1]),
			.ram       (rreq[k]),
			.ram_rdata (rdata[k])
		);

		mipd_ram #(.AW(AW)) u_ram (
			.clk   (clk),
			.re    (rreq[k].re),
			.raddr (rreq[k].raddr[AW-1:0]),
			.rdata (rdata[k]),
			.we    (rreq[k].we),
			.waddr (rreq[k].waddr[AW-1:0]),
			.wdata (rreq[k].wdata)
		);
	end

	assign push = en & chain[NG].vld & (chain[NG].nres != 4'd0);

	assign head          = fifo_q[rp_q];
	assign r             = head.res[slot_q];
	assign last          = slot_q == head.nres - 4'd1;
	assign m_axis_tvalid = cnt_q != 3'd0;
	assign m_axis_tlast  = last;
	assign m_axis_tdata  = {2'b00, r.pix, r.y, r.x, slot_q + 4'd1};
	assign pop           = m_axis_tvalid & m_axis_tready & last;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= {chain[NG].nres, chain[NG].res};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			cnt_q  <= '0;
			slot_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop)  rp_q <= rp_q + 2'd1;
			if (push && !pop) cnt_q <= cnt_q + 3'd1;
			else if (pop && !push) cnt_q <= cnt_q - 3'd1;
			if (m_axis_tvalid && m_axis_tready) begin
				slot_q <= last ? 4'd0 : slot_q + 4'd1;
			end
		end
	end

endmodule
`default_nettype wire
